// File: hw/rtl/fca_pkg.sv
// Shared types, widths, register indexes and format codes for the frame channel averager.
// No dependencies; every other file imports this package.
package fca_pkg;

  localparam int DIM_W     = 13;
  localparam int FMT_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int SUM_W     = 32;
  localparam int MEAN_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CH    = 3;

  typedef logic [FMT_W-1:0] fmt_t;
  typedef logic [1:0]       ch_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam fmt_t FMT_RGBX   = 2'd0;
  localparam fmt_t FMT_BGRX   = 2'd1;
  localparam fmt_t FMT_YCBYCR = 2'd2;
  localparam fmt_t FMT_CBYCRY = 2'd3;

  localparam ch_t CH_FIRST  = 2'd0;
  localparam ch_t CH_SECOND = 2'd1;
  localparam ch_t CH_THIRD  = 2'd2;
  localparam ch_t CH_NONE   = 2'd3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Maps the two low bits of the byte column to a channel sum, or to none.
  function automatic ch_t channel_of(fmt_t fmt, logic [1:0] q);
    ch_t ch;
    case (fmt)
      FMT_RGBX: ch = q;
      FMT_BGRX: ch = (q == 2'd3) ? CH_NONE : ch_t'(2'd2 - q);
      FMT_YCBYCR: ch = !q[0] ? CH_FIRST : ((q == 2'd1) ? CH_SECOND : CH_THIRD);
      default: ch = q[0] ? CH_FIRST : ((q == 2'd0) ? CH_SECOND : CH_THIRD);
    endcase
    return ch;
  endfunction

endpackage

// File: hw/rtl/fca_channels.sv
// Valid/ready channel interfaces for pixel byte requests and mean result requests.
// Depends on fca_pkg for the payload widths.
interface fca_pix_if import fca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;
  logic              start_of_frame;

  modport source (output valid, output pixel_byte, output start_of_frame, input ready);
  modport sink   (input valid, input pixel_byte, input start_of_frame, output ready);
endinterface

interface fca_mean_if import fca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] mean_first;
  logic [MEAN_W-1:0] mean_second;
  logic [MEAN_W-1:0] mean_third;

  modport source (output valid, output mean_first, output mean_second, output mean_third,
                  input ready);
  modport sink   (input valid, input mean_first, input mean_second, input mean_third,
                  output ready);
endinterface

// File: hw/rtl/frame_channel_average.sv
// Top level of the frame channel averager: byte accumulation, sequencer and shared divider.
// Depends on fca_pkg and the channel interfaces in fca_channels.sv.
//
// Channel   Dir  Request content
// pix_i     in   pixel_byte, start_of_frame
// mean_o    out  mean_first, mean_second, mean_third (unsigned Q8.8)
// cfg_*     in   frame_format, frame_width, frame_height writes
//
// A byte that does not end the frame leaves the input ready for the next byte.
// The last byte of a frame holds the input off through one multiply, one add, then a load
// step and a shared 17-step restoring divider once per channel, plus the output load.
// A zero divisor or a saturated mean ends its channel after one divider step, and the output
// load waits while an earlier result is still unaccepted.
// Reset clears counters, sums and the output valid, and restores the configuration defaults.
// The finished result waits in its own register, so bytes are taken while it stalls.
module frame_channel_average import fca_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fca_pix_if.sink              pix_i,
  fca_mean_if.source           mean_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIM_W-1:0]     cfg_data_i
);

  localparam int W_W     = $clog2(MAX_WIDTH + 1);
  localparam int H_W     = $clog2(MAX_HEIGHT + 1);
  localparam int LINES_W = $clog2((MAX_HEIGHT + 1) / 2 + 1);
  localparam int COL_W   = $clog2(4 * MAX_WIDTH);
  localparam int LINE_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BPL_W   = W_W + 2;
  localparam int DIV_W   = W_W + LINES_W;
  localparam int DSH_W   = DIV_W + MEAN_W;
  localparam int NUM_W   = ((SUM_W + FRAC_BITS > DIV_W) ? SUM_W + FRAC_BITS : DIV_W) + 1;
  localparam int CMP_W   = ((NUM_W > DSH_W) ? NUM_W : DSH_W) + 1;
  localparam int CNT_W   = $clog2(MEAN_W + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DY   = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_ITER = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]        state_q, state_d;
  fmt_t              fmt_q;
  logic [DIM_W-1:0]  width_q, height_q;
  logic [COL_W-1:0]  col_q, col_d, col_eff;
  logic [LINE_W-1:0] line_q, line_d, line_eff;
  logic [SUM_W-1:0]  sum_q [NUM_CH];
  logic [SUM_W-1:0]  sum_d [NUM_CH];
  logic [SUM_W-1:0]  sum_base [NUM_CH];
  logic [SUM_W:0]    sum_add [NUM_CH];
  ch_t               ch_q, ch_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  logic [NUM_W-1:0]  num_q, num_d;
  logic [DSH_W-1:0]  dsh_q, dsh_d;
  logic [MEAN_W-1:0] quo_q, quo_d;
  logic              zero_q, zero_d;
  logic [DIV_W-1:0]  dc_q, dy_q;
  logic [MEAN_W-1:0] mean_q [NUM_CH];
  logic [MEAN_W-1:0] mean_val;
  logic              mean_we;
  logic [MEAN_W-1:0] out_first_q, out_second_q, out_third_q;

  logic [DIM_W:0]     w_ext, h_ext;
  logic [W_W-1:0]     w_c;
  logic [H_W-1:0]     h_c;
  logic [LINES_W-1:0] lines;
  logic [BPL_W-1:0]   bpl;
  logic               acc, sof, line_end, frame_end, take, ge, out_free, ch_done;
  ch_t                ch_in;
  logic [DIV_W-1:0]   div_sel;
  logic [SUM_W-1:0]   sum_sel;

  // Clamped frame geometry.
  always_comb begin
    w_ext = {1'b0, width_q};
    h_ext = {1'b0, height_q};
    if (w_ext == '0) begin
      w_ext = (DIM_W + 1)'(1);
    end else if (w_ext > (DIM_W + 1)'(MAX_WIDTH)) begin
      w_ext = (DIM_W + 1)'(MAX_WIDTH);
    end
    if (h_ext == '0) begin
      h_ext = (DIM_W + 1)'(1);
    end else if (h_ext > (DIM_W + 1)'(MAX_HEIGHT)) begin
      h_ext = (DIM_W + 1)'(MAX_HEIGHT);
    end
    w_c   = w_ext[W_W-1:0];
    h_c   = h_ext[H_W-1:0];
    lines = LINES_W'(((H_W + 1)'(h_c) + (H_W + 1)'(1)) >> 1);
    bpl   = fmt_q[1] ? (BPL_W'(w_c) << 1) : (BPL_W'(w_c) << 2);
  end

  // Byte accumulation.
  assign acc       = pix_i.valid && pix_i.ready;
  assign sof       = pix_i.start_of_frame;
  assign col_eff   = sof ? '0 : col_q;
  assign line_eff  = sof ? '0 : line_q;
  assign ch_in     = channel_of(fmt_q, col_eff[1:0]);
  assign take      = !line_eff[0] && (ch_in != CH_NONE);
  assign line_end  = BPL_W'(col_eff) >= (bpl - BPL_W'(1));
  assign frame_end = line_end && (H_W'(line_eff) >= (h_c - H_W'(1)));
  assign out_free  = !out_valid_q || mean_o.ready;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum_base[k] = sof ? '0 : sum_q[k];
      sum_add[k]  = {1'b0, sum_base[k]} + (SUM_W + 1)'(pix_i.pixel_byte);
      sum_d[k]    = sum_q[k];
      if (state_q == ST_IDLE && acc) begin
        sum_d[k] = sum_base[k];
        if (take && ch_in == ch_t'(k)) begin
          sum_d[k] = sum_add[k][SUM_W] ? '1 : sum_add[k][SUM_W-1:0];
        end
      end else if (state_q == ST_OUT && out_free) begin
        sum_d[k] = '0;
      end
    end
  end

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    if (state_q == ST_IDLE && acc) begin
      if (frame_end) begin
        col_d  = '0;
        line_d = '0;
      end else if (line_end) begin
        col_d  = '0;
        line_d = line_eff + LINE_W'(1);
      end else begin
        col_d  = col_eff + COL_W'(1);
        line_d = line_eff;
      end
    end
  end

  // Shared restoring divider and its sequencer.
  assign div_sel = (!fmt_q[1] || ch_q == CH_FIRST) ? dy_q : dc_q;
  assign sum_sel = sum_q[ch_q];
  assign ge      = CMP_W'(num_q) >= CMP_W'(dsh_q);

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    zero_d      = zero_q;
    mean_we     = 1'b0;
    mean_val    = '0;
    ch_done     = 1'b0;
    out_valid_d = out_valid_q && !mean_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (acc && frame_end) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_DY;
      end
      ST_DY: begin
        ch_d    = CH_FIRST;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        num_d   = NUM_W'({sum_sel, {FRAC_BITS{1'b0}}}) + NUM_W'(div_sel >> 1);
        dsh_d   = {div_sel, {MEAN_W{1'b0}}};
        zero_d  = (div_sel == '0);
        cnt_d   = CNT_W'(MEAN_W);
        quo_d   = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (cnt_q == CNT_W'(MEAN_W)) begin
          if (zero_q) begin
            mean_we = 1'b1;
            ch_done = 1'b1;
          end else if (ge) begin
            mean_we  = 1'b1;
            mean_val = '1;
            ch_done  = 1'b1;
          end else begin
            dsh_d = dsh_q >> 1;
            cnt_d = cnt_q - CNT_W'(1);
          end
        end else begin
          if (ge) begin
            num_d = NUM_W'(CMP_W'(num_q) - CMP_W'(dsh_q));
          end
          quo_d = {quo_q[MEAN_W-2:0], ge};
          dsh_d = dsh_q >> 1;
          if (cnt_q == '0) begin
            mean_we  = 1'b1;
            mean_val = {quo_q[MEAN_W-2:0], ge};
            ch_done  = 1'b1;
          end else begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        if (ch_done) begin
          if (ch_q == CH_THIRD) begin
            state_d = ST_OUT;
          end else begin
            ch_d    = ch_q + ch_t'(1);
            state_d = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fmt_q       <= FMT_RGBX;
      width_q     <= WIDTH_RESET;
      height_q    <= HEIGHT_RESET;
      col_q       <= '0;
      line_q      <= '0;
      ch_q        <= CH_FIRST;
      cnt_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        sum_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      line_q      <= line_d;
      ch_q        <= ch_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
      for (int k = 0; k < NUM_CH; k++) begin
        sum_q[k] <= sum_d[k];
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FORMAT: fmt_q <= cfg_data_i[FMT_W-1:0];
          CFG_WIDTH:  width_q <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
    if (state_q == ST_MUL) begin
      dc_q <= DIV_W'((W_W - 1)'(w_c >> 1) * lines);
    end
    if (state_q == ST_DY) begin
      dy_q <= {dc_q[DIV_W-2:0], 1'b0} + (w_c[0] ? DIV_W'(lines) : '0);
    end
    if (mean_we) begin
      mean_q[ch_q] <= mean_val;
    end
    if (state_q == ST_OUT && out_free) begin
      out_first_q  <= mean_q[CH_FIRST];
      out_second_q <= mean_q[CH_SECOND];
      out_third_q  <= mean_q[CH_THIRD];
    end
  end

  assign pix_i.ready        = (state_q == ST_IDLE);
  assign mean_o.valid       = out_valid_q;
  assign mean_o.mean_first  = out_first_q;
  assign mean_o.mean_second = out_second_q;
  assign mean_o.mean_third  = out_third_q;

  // The counters restart after the last byte of a frame.
  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && frame_end) |=> (col_q == '0 && line_q == '0 && state_q == ST_MUL))
    else $error("counters not cleared at frame end");

  // The partial remainder stays below twice the shifted divisor while quotient bits form.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ITER && cnt_q != CNT_W'(MEAN_W))
      |-> ((CMP_W + 1)'(num_q) < ((CMP_W + 1)'(dsh_q) << 1)))
    else $error("divider remainder out of range");

  // A new result is only raised by the output step of the sequencer.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || mean_o.ready) && out_valid_d |-> state_q == ST_OUT)
    else $error("result raised outside the output step");

  // Bytes are refused while a frame result is being computed.
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD || state_q == ST_ITER) |-> (!pix_i.ready && !acc))
    else $error("byte accepted during division");

endmodule
